FILE: hdl/kmcr_pkg.sv
// ----------------------------------------------------------------------------
// kmcr_pkg
// Types, constants and the keycode table of the keypad change reporter.
// ----------------------------------------------------------------------------
package kmcr_pkg;

  localparam int KEY_WIDTH    = 20;
  localparam int INDEX_WIDTH  = 5;
  localparam int CODE_WIDTH   = 8;
  localparam int CFG_IDX_WIDTH = 2;

  localparam int ROW_COUNT_DEFAULT    = 5;
  localparam int COLUMN_COUNT_DEFAULT = 4;

  localparam logic [INDEX_WIDTH-1:0] PTT_INDEX = 5'd20;
  localparam logic [INDEX_WIDTH-1:0] OPT_INDEX = 5'd21;

  localparam logic [CODE_WIDTH-1:0] CODE_NONE      = 8'd0;
  localparam logic [CODE_WIDTH-1:0] CODE_ENTER     = 8'd28;
  localparam logic [CODE_WIDTH-1:0] CODE_PAD_STAR  = 8'd55;
  localparam logic [CODE_WIDTH-1:0] CODE_BACKSLASH = 8'd43;
  localparam logic [CODE_WIDTH-1:0] KEY_P          = 8'd25;
  localparam logic [CODE_WIDTH-1:0] KEY_O          = 8'd24;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_PTT_INTERNAL = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PTT_EXTERNAL = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_OPT          = 2'd2;

  typedef struct packed {
    logic [KEY_WIDTH-1:0] key_levels;
    logic                 ptt_internal_level;
    logic                 ptt_external_level;
    logic                 opt_level;
  } poll_t;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0] key_index;
    logic [CODE_WIDTH-1:0]  key_code;
    logic                   key_pressed;
    logic                   last_event;
  } event_t;

  typedef struct packed {
    logic                 valid;
    logic [KEY_WIDTH-1:0] changed;
    logic [KEY_WIDTH-1:0] now;
    logic                 ptt_pend;
    logic                 ptt_val;
    logic                 opt_pend;
    logic                 opt_val;
  } scan_load_t;

  typedef struct packed {
    logic   valid;
    event_t item;
  } emit_t;

  function automatic logic [CODE_WIDTH-1:0] key_code_of(logic [INDEX_WIDTH-1:0] idx);
    logic [CODE_WIDTH-1:0] code;
    case (idx)
      5'd0:    code = CODE_ENTER;
      5'd1:    code = 8'd103;
      5'd2:    code = 8'd108;
      5'd3:    code = 8'd1;
      5'd4:    code = 8'd105;
      5'd5:    code = 8'd106;
      5'd6:    code = 8'd2;
      5'd7:    code = 8'd3;
      5'd8:    code = 8'd4;
      5'd9:    code = 8'd5;
      5'd10:   code = 8'd6;
      5'd11:   code = 8'd7;
      5'd12:   code = 8'd8;
      5'd13:   code = 8'd9;
      5'd14:   code = 8'd10;
      5'd15:   code = CODE_PAD_STAR;
      5'd16:   code = 8'd11;
      5'd17:   code = CODE_BACKSLASH;
      default: code = CODE_NONE;
    endcase
    return code;
  endfunction

endpackage

FILE: hdl/kmcr_scan.sv
// ----------------------------------------------------------------------------
// kmcr_scan
// Bit-serial scan of the changed-key vector, then push-to-talk and option.
// ----------------------------------------------------------------------------
module kmcr_scan (
  input  logic               clk,
  input  logic               rst,
  input  kmcr_pkg::scan_load_t load,
  input  logic               slot_free,
  output logic               busy,
  output kmcr_pkg::emit_t    emit
);
  import kmcr_pkg::*;

  logic [KEY_WIDTH-1:0]   chg_sr;
  logic [KEY_WIDTH-1:0]   now_sr;
  logic [INDEX_WIDTH-1:0] idx;
  logic                   ptt_pend;
  logic                   ptt_val;
  logic                   opt_pend;
  logic                   opt_val;
  logic                   cand;
  logic                   step;
  event_t                 item;

  always_comb begin
    cand = 1'b0;
    step = 1'b0;
    item = '0;
    if (chg_sr != '0) begin
      cand             = chg_sr[0];
      step             = !chg_sr[0] || slot_free;
      item.key_index   = idx;
      item.key_code    = key_code_of(idx);
      item.key_pressed = now_sr[0];
      item.last_event  = (chg_sr[KEY_WIDTH-1:1] == '0) && !ptt_pend && !opt_pend;
    end else if (ptt_pend) begin
      cand             = 1'b1;
      step             = slot_free;
      item.key_index   = PTT_INDEX;
      item.key_code    = KEY_P;
      item.key_pressed = ptt_val;
      item.last_event  = !opt_pend;
    end else if (opt_pend) begin
      cand             = 1'b1;
      step             = slot_free;
      item.key_index   = OPT_INDEX;
      item.key_code    = KEY_O;
      item.key_pressed = opt_val;
      item.last_event  = 1'b1;
    end
  end

  assign emit.valid = busy && cand && slot_free;
  assign emit.item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      chg_sr   <= '0;
      ptt_pend <= 1'b0;
      opt_pend <= 1'b0;
    end else if (load.valid) begin
      chg_sr   <= load.changed;
      now_sr   <= load.now;
      idx      <= '0;
      ptt_pend <= load.ptt_pend;
      ptt_val  <= load.ptt_val;
      opt_pend <= load.opt_pend;
      opt_val  <= load.opt_val;
      busy     <= (load.changed != '0) || load.ptt_pend || load.opt_pend;
    end else if (busy && step) begin
      if (chg_sr != '0) begin
        chg_sr <= chg_sr >> 1;
        now_sr <= now_sr >> 1;
        idx    <= idx + 1'b1;
      end else if (ptt_pend) begin
        ptt_pend <= 1'b0;
      end else begin
        opt_pend <= 1'b0;
      end
      if (emit.valid && item.last_event) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/kmcr_out.sv
// ----------------------------------------------------------------------------
// kmcr_out
// Output register of the event channel.
// ----------------------------------------------------------------------------
module kmcr_out (
  input  logic              clk,
  input  logic              rst,
  input  kmcr_pkg::emit_t   emit,
  output logic              slot_free,
  output logic              evt_valid,
  input  logic              evt_stall,
  output kmcr_pkg::event_t  evt_data
);
  import kmcr_pkg::*;

  assign slot_free = !evt_valid || !evt_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (emit.valid) begin
      evt_valid <= 1'b1;
    end else if (!evt_stall) begin
      evt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      evt_data <= emit.item;
    end
  end

endmodule

FILE: hdl/keypad_matrix_change_reporter_top.sv
// A poll's first event passes the bit-serial scan registers, which step past
// unchanged positions below the lowest changed key, then the output register.
// Scan: one key position per cycle, held at a changed key while the output
// slot is taken, up to the highest changed key, then push-to-talk and option
// where they changed. A poll with no change is free the next cycle. Output
// stalls hold the scan. Synchronous reset clears state, not data registers.
// ----------------------------------------------------------------------------
// keypad_matrix_change_reporter_top
// Keeps the last pressed set and line levels, reports changes as events.
// ----------------------------------------------------------------------------
module keypad_matrix_change_reporter_top #(
  parameter int ROW_COUNT    = kmcr_pkg::ROW_COUNT_DEFAULT,
  parameter int COLUMN_COUNT = kmcr_pkg::COLUMN_COUNT_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 poll_valid,
  output logic                                 poll_stall,
  input  kmcr_pkg::poll_t                      poll_data,
  output logic                                 evt_valid,
  input  logic                                 evt_stall,
  output kmcr_pkg::event_t                     evt_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [kmcr_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic                                 cfg_data
);
  import kmcr_pkg::*;

  localparam int KEY_COUNT = (ROW_COUNT * COLUMN_COUNT > KEY_WIDTH) ?
                             KEY_WIDTH : ROW_COUNT * COLUMN_COUNT;
  localparam logic [KEY_WIDTH-1:0] KEY_MASK = {KEY_WIDTH{1'b1}} >> (KEY_WIDTH - KEY_COUNT);

  logic                 ptt_internal_present;
  logic                 ptt_external_present;
  logic                 opt_present;
  logic [KEY_WIDTH-1:0] pressed_set;
  logic                 ptt_previous;
  logic                 opt_previous;
  logic                 busy;
  logic                 slot_free;
  logic                 accept;
  logic [KEY_WIDTH-1:0] now;
  logic                 ptt_fitted;
  logic                 ptt_comb;
  scan_load_t           load;
  emit_t                emit;

  assign cfg_ready  = 1'b1;
  assign poll_stall = busy;
  assign accept     = poll_valid && !busy;

  assign now        = ~poll_data.key_levels & KEY_MASK;
  assign ptt_fitted = ptt_internal_present || ptt_external_present;
  assign ptt_comb   = (ptt_internal_present && poll_data.ptt_internal_level) ||
                      (ptt_external_present && poll_data.ptt_external_level);

  always_comb begin
    load.valid    = accept;
    load.changed  = now ^ pressed_set;
    load.now      = now;
    load.ptt_pend = ptt_fitted && (ptt_comb != ptt_previous);
    load.ptt_val  = !ptt_comb;
    load.opt_pend = opt_present && (poll_data.opt_level != opt_previous);
    load.opt_val  = !poll_data.opt_level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptt_internal_present <= 1'b0;
      ptt_external_present <= 1'b0;
      opt_present          <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PTT_INTERNAL: ptt_internal_present <= cfg_data;
        REG_PTT_EXTERNAL: ptt_external_present <= cfg_data;
        REG_OPT:          opt_present          <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_set  <= '0;
      ptt_previous <= 1'b0;
      opt_previous <= 1'b0;
    end else if (accept) begin
      pressed_set <= now;
      if (ptt_fitted) begin
        ptt_previous <= ptt_comb;
      end
      if (opt_present) begin
        opt_previous <= poll_data.opt_level;
      end
    end
  end

  kmcr_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .slot_free (slot_free),
    .busy      (busy),
    .emit      (emit)
  );

  kmcr_out u_out (
    .clk       (clk),
    .rst       (rst),
    .emit      (emit),
    .slot_free (slot_free),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt_data  (evt_data)
  );

endmodule

FILE: hdl/kmcr_checker.sv
// ----------------------------------------------------------------------------
// kmcr_checker
// Port-level checks of the keypad change reporter, bound to the top level.
// ----------------------------------------------------------------------------
module kmcr_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              poll_stall,
  input  logic              evt_valid,
  input  logic              evt_stall,
  input  kmcr_pkg::event_t  evt_data
);
  import kmcr_pkg::*;

  a_evt_hold: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_stall |=> evt_valid && $stable(evt_data))
    else $error("stalled event changed");

  a_poll_open: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt_data.last_event |-> poll_stall)
    else $error("new poll taken before its events were done");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    evt_valid |-> evt_data.key_index <= OPT_INDEX)
    else $error("event index out of range");

  a_ptt_code: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_data.key_index == PTT_INDEX |-> evt_data.key_code == KEY_P)
    else $error("push-to-talk event with wrong keycode");

  a_opt_last: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_data.key_index == OPT_INDEX |-> evt_data.last_event)
    else $error("option event not last of poll");

endmodule

bind keypad_matrix_change_reporter_top kmcr_checker u_kmcr_checker (
  .clk        (clk),
  .rst        (rst),
  .poll_stall (poll_stall),
  .evt_valid  (evt_valid),
  .evt_stall  (evt_stall),
  .evt_data   (evt_data)
);
